// ===== design/iwlt_pkg.sv =====
`timescale 1ns / 1ps

package iwlt_pkg;

  localparam int CAPACITY   = 256;
  localparam int WORD_BITS  = 32;

  localparam int POS_W      = 10;
  localparam int LEN_W      = 9;
  localparam int OP_W       = 3;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 56;

  localparam int CNT_W      = $clog2(CAPACITY + 1);
  // wide enough for any entry index, the count and a non-negative position
  localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam int GROUP_SIZE = 16;
  localparam int GRP_W      = $clog2(GROUP_SIZE);
  localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

  typedef enum logic [2:0] {
    OP_INSERT   = 3'd0,
    OP_DELETE   = 3'd1,
    OP_DELRANGE = 3'd2,
    OP_GET      = 3'd3,
    OP_SET      = 3'd4,
    OP_FIND     = 3'd5,
    OP_CLEAR    = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT_UP,
    CELL_SHIFT_DOWN,
    CELL_SET
  } cell_op_t;

  // broadcast to every cell; word doubles as the search key
  typedef struct packed {
    cell_op_t               kind;
    logic [CMP_W-1:0]       at;
    logic [CMP_W-1:0]       count;
    logic [WORD_BITS-1:0]   word;
  } cell_cmd_t;

  typedef struct packed {
    logic                   any;
    logic [GRP_W-1:0]       first;
    logic [WORD_BITS-1:0]   rd_word;
  } group_res_t;

endpackage

// ===== design/iwlt_cell.sv =====
`timescale 1ns / 1ps

module iwlt_cell (
  input  logic                                clk,
  input  iwlt_pkg::cell_cmd_t                 cmd,
  input  logic [iwlt_pkg::CMP_W-1:0]          idx,
  input  logic [iwlt_pkg::WORD_BITS-1:0]      prev_word,
  input  logic [iwlt_pkg::WORD_BITS-1:0]      next_word,
  output logic [iwlt_pkg::WORD_BITS-1:0]      word,
  output logic                                match,
  output logic                                hit
);

  always_ff @(posedge clk) begin
    unique case (cmd.kind)
      iwlt_pkg::CELL_HOLD: begin
      end
      iwlt_pkg::CELL_SHIFT_UP: begin
        if (idx > cmd.at) begin
          word <= prev_word;
        end else if (idx == cmd.at) begin
          word <= cmd.word;
        end
      end
      iwlt_pkg::CELL_SHIFT_DOWN: begin
        if (idx >= cmd.at) begin
          word <= next_word;
        end
      end
      iwlt_pkg::CELL_SET: begin
        if (idx == cmd.at) begin
          word <= cmd.word;
        end else if (idx >= cmd.count && idx < cmd.at) begin
          word <= '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign match = (word == cmd.word) && (idx < cmd.count);
  assign hit   = (idx == cmd.at);

endmodule

// ===== design/iwlt_group.sv =====
`timescale 1ns / 1ps

// first match and selected word over one group of cells, registered
module iwlt_group (
  input  logic                                                  clk,
  input  logic [iwlt_pkg::GROUP_SIZE-1:0]                       match,
  input  logic [iwlt_pkg::GROUP_SIZE-1:0]                       hit,
  input  logic [iwlt_pkg::GROUP_SIZE-1:0][iwlt_pkg::WORD_BITS-1:0] words,
  output iwlt_pkg::group_res_t                                  res
);

  iwlt_pkg::group_res_t res_next;

  always_comb begin
    res_next = '0;
    for (int k = iwlt_pkg::GROUP_SIZE - 1; k >= 0; k--) begin
      if (match[k]) begin
        res_next.any   = 1'b1;
        res_next.first = iwlt_pkg::GRP_W'(k);
      end
      if (hit[k]) begin
        res_next.rd_word = res_next.rd_word | words[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

endmodule

// ===== design/indexed_word_list_table.sv =====
`timescale 1ns / 1ps

// Ordered word list with a live count, held in a chain of cells, one word per
// cell. A request beat carries the opcode on s_tuser and its arguments on
// s_tdata; every request returns exactly one result beat with the status on
// m_tuser. Insert and delete shift the cells from the given position onward by
// one place, each cell taking its neighbor's word. Get, delete and find go
// through a registered read tree (groups of 16 cells, then one level over the
// groups), whose register is loaded as the request is accepted. Delete range
// shifts the chain down one place per cycle for each removed entry, the last
// shift waiting until the result beat can be loaded. Requests are taken
// one at a time; a new one is accepted while the previous result beat still
// waits on m_tready. Entries beyond the count are never visible, so the
// chain needs no clearing after reset.
module indexed_word_list_table (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [9:0] position (signed), [41:10] data_word, [50:42] range_length, rest zero
  input  logic [iwlt_pkg::IN_DATA_W-1:0]     s_tdata,
  // [2:0] opcode
  input  logic [iwlt_pkg::OP_W-1:0]          s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [7:0] result_position, [39:8] result_word, [48:40] entry_count, rest zero
  output logic [iwlt_pkg::OUT_DATA_W-1:0]    m_tdata,
  // [1:0] status
  output logic [1:0]                         m_tuser
);

  localparam int CMP_W = iwlt_pkg::CMP_W;
  localparam int CNT_W = iwlt_pkg::CNT_W;
  localparam int WB    = iwlt_pkg::WORD_BITS;
  localparam int GS    = iwlt_pkg::GROUP_SIZE;
  localparam int NG    = iwlt_pkg::NUM_GROUPS;
  localparam int CAP   = iwlt_pkg::CAPACITY;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_FINISH = 3'b010,
    S_SHIFT  = 3'b100
  } state_t;

  state_t state, state_next;

  // latched request
  logic [iwlt_pkg::OP_W-1:0]  req_op;
  logic [iwlt_pkg::POS_W-1:0] req_pos;
  logic [WB-1:0]              req_word;
  logic [iwlt_pkg::LEN_W-1:0] req_len;

  logic [CNT_W-1:0] count, count_next;
  logic [CMP_W-1:0] rem, rem_next;

  // result beat register
  logic [1:0]       out_status;
  logic [7:0]       out_rpos;
  logic [31:0]      out_rword;
  logic [8:0]       out_count;

  logic             load;
  logic [1:0]       res_status;
  logic [7:0]       res_rpos;
  logic [31:0]      res_rword;

  iwlt_pkg::cell_cmd_t cmd;

  // chain and read tree
  logic [WB-1:0]                   cell_word [CAP];
  logic [CAP-1:0]                  cell_match;
  logic [CAP-1:0]                  cell_hit;
  logic [NG*GS-1:0]                pad_match;
  logic [NG*GS-1:0]                pad_hit;
  logic [GS-1:0][WB-1:0]           grp_words [NG];
  iwlt_pkg::group_res_t            grp_res [NG];

  logic             found;
  logic [CMP_W-1:0] found_idx;
  logic [WB-1:0]    rd_word;

  // request decode
  logic             pos_neg;
  logic [CMP_W-1:0] pos_ext, count_ext, len_ext, avail, del_n, ins_at;
  logic             in_list;
  logic             go;

  genvar gi, gk;
  generate
    for (gi = 0; gi < CAP; gi++) begin : g_cell
      logic [WB-1:0] prev_w, next_w;
      if (gi == 0) begin : g_first
        assign prev_w = '0;
      end else begin : g_mid_p
        assign prev_w = cell_word[gi-1];
      end
      if (gi == CAP - 1) begin : g_last
        assign next_w = cell_word[gi];
      end else begin : g_mid_n
        assign next_w = cell_word[gi+1];
      end
      iwlt_cell u_cell (
        .clk       (clk),
        .cmd       (cmd),
        .idx       (CMP_W'(gi)),
        .prev_word (prev_w),
        .next_word (next_w),
        .word      (cell_word[gi]),
        .match     (cell_match[gi]),
        .hit       (cell_hit[gi])
      );
    end

    for (gi = 0; gi < NG; gi++) begin : g_grp
      for (gk = 0; gk < GS; gk++) begin : g_slot
        if (gi * GS + gk < CAP) begin : g_real
          assign pad_match[gi*GS+gk] = cell_match[gi*GS+gk];
          assign pad_hit[gi*GS+gk]   = cell_hit[gi*GS+gk];
          assign grp_words[gi][gk]   = cell_word[gi*GS+gk];
        end else begin : g_pad
          assign pad_match[gi*GS+gk] = 1'b0;
          assign pad_hit[gi*GS+gk]   = 1'b0;
          assign grp_words[gi][gk]   = '0;
        end
      end
      iwlt_group u_group (
        .clk   (clk),
        .match (pad_match[gi*GS +: GS]),
        .hit   (pad_hit[gi*GS +: GS]),
        .words (grp_words[gi]),
        .res   (grp_res[gi])
      );
    end
  endgenerate

  // second tree level: first group with a match, OR of selected words
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    rd_word   = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_res[g].any) begin
        found     = 1'b1;
        found_idx = CMP_W'(g * GS) + CMP_W'(grp_res[g].first);
      end
      rd_word = rd_word | grp_res[g].rd_word;
    end
  end

  assign pos_neg   = req_pos[iwlt_pkg::POS_W-1];
  assign pos_ext   = CMP_W'(req_pos[iwlt_pkg::POS_W-2:0]);
  assign count_ext = CMP_W'(count);
  assign len_ext   = CMP_W'(req_len);
  assign in_list   = !pos_neg && (pos_ext < count_ext);
  assign avail     = count_ext - pos_ext;
  assign del_n     = (len_ext < avail) ? len_ext : avail;
  assign ins_at    = (pos_neg || pos_ext > count_ext) ? count_ext : pos_ext;
  assign go        = !m_tvalid || m_tready;
  // no beat is taken while reset is held
  assign s_tready  = (state == S_IDLE) && !rst;

  always_comb begin
    state_next = state;
    count_next = count;
    rem_next   = rem;
    load       = 1'b0;
    res_status = iwlt_pkg::ST_OK;
    res_rpos   = '0;
    res_rword  = '0;
    cmd.kind   = iwlt_pkg::CELL_HOLD;
    cmd.count  = count_ext;
    if (state == S_IDLE) begin
      // look-up key and index straight off the beat, for the read tree
      cmd.at   = CMP_W'(s_tdata[iwlt_pkg::POS_W-2:0]);
      cmd.word = WB'(s_tdata[41:10]);
    end else begin
      cmd.at   = pos_ext;
      cmd.word = req_word;
    end

    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_FINISH;
        end
      end

      S_FINISH: begin
        if (req_op == iwlt_pkg::OP_DELRANGE && in_list && del_n != '0) begin
          rem_next   = del_n;
          state_next = S_SHIFT;
        end else if (go) begin
          load       = 1'b1;
          state_next = S_IDLE;
          case (req_op)
            iwlt_pkg::OP_INSERT: begin
              if (count == CNT_W'(CAP)) begin
                res_status = iwlt_pkg::ST_FULL;
              end else begin
                cmd.kind   = iwlt_pkg::CELL_SHIFT_UP;
                cmd.at     = ins_at;
                count_next = CNT_W'(count + 1'b1);
                res_rpos   = ins_at[7:0];
              end
            end
            iwlt_pkg::OP_DELETE: begin
              if (!in_list) begin
                res_status = iwlt_pkg::ST_RANGE;
              end else begin
                cmd.kind   = iwlt_pkg::CELL_SHIFT_DOWN;
                count_next = CNT_W'(count - 1'b1);
                res_rword  = 32'(rd_word);
              end
            end
            iwlt_pkg::OP_DELRANGE: begin
              // only the failing and zero-length cases end here
              if (!in_list) begin
                res_status = iwlt_pkg::ST_RANGE;
              end
            end
            iwlt_pkg::OP_GET: begin
              if (!in_list) begin
                res_status = iwlt_pkg::ST_RANGE;
              end else begin
                res_rword = 32'(rd_word);
              end
            end
            iwlt_pkg::OP_SET: begin
              if (pos_neg) begin
                res_status = iwlt_pkg::ST_RANGE;
              end else if (pos_ext >= CMP_W'(CAP)) begin
                res_status = iwlt_pkg::ST_FULL;
              end else begin
                cmd.kind = iwlt_pkg::CELL_SET;
                if (pos_ext >= count_ext) begin
                  count_next = CNT_W'(pos_ext + 1'b1);
                end
              end
            end
            iwlt_pkg::OP_FIND: begin
              if (found) begin
                res_rpos = found_idx[7:0];
              end else begin
                res_status = iwlt_pkg::ST_NOTFOUND;
              end
            end
            iwlt_pkg::OP_CLEAR: begin
              count_next = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_SHIFT: begin
        // last shift only when the result beat can be loaded
        if (rem != CMP_W'(1) || go) begin
          cmd.kind   = iwlt_pkg::CELL_SHIFT_DOWN;
          count_next = CNT_W'(count - 1'b1);
          rem_next   = CMP_W'(rem - 1'b1);
          if (rem == CMP_W'(1)) begin
            load       = 1'b1;
            state_next = S_IDLE;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      rem      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      rem   <= rem_next;
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req_op   <= s_tuser;
      req_pos  <= s_tdata[9:0];
      req_word <= WB'(s_tdata[41:10]);
      req_len  <= s_tdata[50:42];
    end
    if (load) begin
      out_status <= res_status;
      out_rpos   <= res_rpos;
      out_rword  <= res_rword;
      out_count  <= 9'(count_next);
    end
  end

  assign m_tdata = {7'b0, out_count, out_rword, out_rpos};
  assign m_tuser = out_status;

endmodule
